### rtl/logm_pkg.sv
// logm_pkg: shared types and codes for the lidar occupancy grid marker
// depends on nothing; used by the controller, datapath and top level
package logm_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_BEAM  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_INVALID = 2'd1,
		ST_JUMP    = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	localparam logic [2:0] CELL_EMPTY  = 3'd0;
	localparam logic [2:0] CELL_OBST   = 3'd1;
	localparam logic [2:0] CELL_ORIGIN = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_CELLS_PER_MM = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP   = 3'd1;
	localparam logic [2:0] REG_HEADING      = 3'd2;
	localparam logic [2:0] REG_ORIGIN_ROW   = 3'd3;
	localparam logic [2:0] REG_ORIGIN_COL   = 3'd4;
	localparam logic [2:0] REG_GRID_ROWS    = 3'd5;
	localparam logic [2:0] REG_GRID_COLS    = 3'd6;
	localparam logic [2:0] REG_JUMP_LIMIT   = 3'd7;

	// reset values of the registers
	localparam logic [23:0] RST_CELLS_PER_MM = 24'd167772;
	localparam logic [23:0] RST_ANGLE_STEP   = 24'd9992;
	localparam logic [23:0] RST_HEADING      = 24'd0;
	localparam logic [6:0]  RST_ORIGIN_ROW   = 7'd30;
	localparam logic [8:0]  RST_ORIGIN_COL   = 9'd50;
	localparam logic [7:0]  RST_GRID_ROWS    = 8'd110;
	localparam logic [9:0]  RST_GRID_COLS    = 10'd360;
	localparam logic [15:0] RST_JUMP_LIMIT   = 16'd30;

	// grid coordinates, wide enough for origin plus any projected offset
	typedef logic signed [19:0] coord_t;

	// stamp counter, covers a radius up to 7
	typedef logic [3:0] span_cnt_t;

	typedef struct packed {
		logic capture;
		logic sweep;
		logic origin_wr;
		logic check;
		logic sine;
		logic cosine;
		logic mul_row;
		logic round_row;
		logic stamp;
		logic read;
		logic read_cap;
		logic out_load;
	} logm_cmd_t;

	typedef struct packed {
		op_t  op;
		logic skip;
		logic sweep_last;
		logic stamp_last;
	} logm_sts_t;

endpackage

### rtl/logm_ram.sv
// logm_ram: generic single-port ram with registered read
// no dependencies
module logm_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### rtl/logm_ctrl.sv
// logm_ctrl: sequencing state machine of the grid marker
// depends on logm_pkg
module logm_ctrl
	import logm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  logm_sts_t sts,
	output logm_cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_CLEAR   = 12'b0000_0000_0010,
		S_ORIGIN  = 12'b0000_0000_0100,
		S_CHECK   = 12'b0000_0000_1000,
		S_SINE    = 12'b0000_0001_0000,
		S_COSINE  = 12'b0000_0010_0000,
		S_MULROW  = 12'b0000_0100_0000,
		S_ROUND   = 12'b0000_1000_0000,
		S_STAMP   = 12'b0001_0000_0000,
		S_READ    = 12'b0010_0000_0000,
		S_READCAP = 12'b0100_0000_0000,
		S_FINISH  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   boot_q;
	logic   load;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (sts.op)
						OP_CLEAR: state_d = S_CLEAR;
						OP_BEAM:  state_d = S_CHECK;
						OP_READ:  state_d = S_READ;
						default:  state_d = S_FINISH;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = S_ORIGIN;
			end
			S_ORIGIN: begin
				cmd.origin_wr = 1'b1;
				// the clearing pass after reset has no result
				state_d       = boot_q ? S_IDLE : S_FINISH;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.skip ? S_FINISH : S_SINE;
			end
			S_SINE: begin
				cmd.sine = 1'b1;
				state_d  = S_COSINE;
			end
			S_COSINE: begin
				cmd.cosine = 1'b1;
				state_d    = S_MULROW;
			end
			S_MULROW: begin
				cmd.mul_row = 1'b1;
				state_d     = S_ROUND;
			end
			S_ROUND: begin
				cmd.round_row = 1'b1;
				state_d       = S_STAMP;
			end
			S_STAMP: begin
				cmd.stamp = 1'b1;
				if (sts.stamp_last) state_d = S_FINISH;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_READCAP;
			end
			S_READCAP: begin
				cmd.read_cap = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (load) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
			boot_q      <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_ORIGIN) begin
				boot_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/logm_dp.sv
// logm_dp: registers, beam geometry, stamp walker and grid memory access
// depends on logm_pkg and logm_ram
module logm_dp
	import logm_pkg::*;
#(
	parameter int ROWS_MAX     = 128,
	parameter int COLS_MAX     = 512,
	parameter int SINE_ENTRIES = 1024,
	parameter int STAMP_RADIUS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logm_cmd_t   cmd,
	output logm_sts_t   sts,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic [1:0]  op,
	input  logic [11:0] beam_index,
	input  logic [15:0] range_mm,
	input  logic [15:0] next_range_mm,
	input  logic        has_next,
	input  logic [6:0]  read_row,
	input  logic [8:0]  read_col,
	output logic [1:0]  status,
	output logic [2:0]  cell_value
);

	localparam int DEPTH = ROWS_MAX * COLS_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int LOG   = $clog2(SINE_ENTRIES);
	localparam int QTR   = SINE_ENTRIES / 4;
	localparam int SPAN  = 2 * STAMP_RADIUS + 1;
	localparam coord_t ROWS_LIM = coord_t'(ROWS_MAX);
	localparam coord_t COLS_LIM = coord_t'(COLS_MAX);
	localparam logic RST_ORG_OK =
		(int'(RST_ORIGIN_ROW) < ((int'(RST_GRID_ROWS) < ROWS_MAX) ? int'(RST_GRID_ROWS) : ROWS_MAX))
		&& (int'(RST_ORIGIN_COL) < ((int'(RST_GRID_COLS) < COLS_MAX) ? int'(RST_GRID_COLS)
		: COLS_MAX));
	localparam logic [AW-1:0] RST_ORG_ADDR =
		AW'(int'(RST_ORIGIN_ROW) * COLS_MAX + int'(RST_ORIGIN_COL));

	function automatic longint mul_q28(input longint a, input longint b);
		if (a < 0) return -(((-a) * b) >>> 28);
		return (a * b) >>> 28;
	endfunction

	// quarter-wave sine at k/QTR of a quarter turn, q1.15
	function automatic longint sine_q15(input int k);
		longint x, x2, acc, v;
		x   = longint'(k) * (longint'(1) << 22) / QTR * 64;
		x2  = mul_q28(x, x);
		acc = 43068;
		acc = -1256749 + mul_q28(acc, x2);
		acc = 21392326 + mul_q28(acc, x2);
		acc = -173399667 + mul_q28(acc, x2);
		acc = 421657428 + mul_q28(acc, x2);
		acc = mul_q28(acc, x);
		if (acc < 0) acc = 0;
		v = (acc + 4096) >>> 13;
		if (v > 32767) v = 32767;
		return v;
	endfunction

	function automatic logic [AW-1:0] cell_addr(input coord_t r, input coord_t c);
		return AW'(32'(r) * 32'(COLS_MAX) + 32'(c));
	endfunction

	// round half away from zero of a q39 product, with sign
	function automatic coord_t round_q39(input logic [54:0] p, input logic neg);
		logic [16:0] m;
		m = 17'((56'(p) + (56'd1 << 38)) >> 39);
		return neg ? -coord_t'(m) : coord_t'(m);
	endfunction

	// configuration registers
	logic [23:0] cells_per_mm_q, angle_step_q, heading_q;
	logic [6:0]  origin_row_q;
	logic [8:0]  origin_col_q;
	logic [7:0]  grid_rows_q;
	logic [9:0]  grid_cols_q;
	logic [15:0] jump_limit_q;

	// captured item
	op_t         op_q;
	logic [11:0] idx_q;
	logic [15:0] range_q, next_q;
	logic        has_next_q;
	logic [6:0]  rrow_q;
	logic [8:0]  rcol_q;

	// work and output registers
	logic            clr_ok_q;
	logic [AW-1:0]   clr_addr_q, sweep_q;
	status_t         status_w_q;
	logic [2:0]      cell_w_q;
	logic [1:0]      status_q;
	logic [2:0]      cell_q;
	logic [23:0]     theta_q;
	logic [39:0]     dist_q;
	logic [15:0]     sin_q, cos_q;
	logic [54:0]     prod_q;
	logic            prod_neg_q;
	coord_t          row_q, col_q;
	span_cnt_t       sj_q, sk_q;

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [2:0]    mem_wdata, mem_rdata;

	logic [14:0]   sine_rom [QTR+1];
	coord_t        eff_rows, eff_cols, nr, nc, org_r, org_c;
	logic          invalid, jump, stamp_in, read_in, org_ok;
	logic [15:0]   diff;
	logic [LOG-1:0] entry, lut_entry;
	logic [1:0]    quad;
	logic [LOG-2:0] lut_k;
	logic [15:0]   lut_val;
	logic [14:0]   mag;

	for (genvar g = 0; g <= QTR; g++) begin : g_rom
		assign sine_rom[g] = 15'(sine_q15(g));
	end

	assign cfg_ready  = 1'b1;
	assign status     = status_q;
	assign cell_value = cell_q;

	assign eff_rows = (coord_t'(grid_rows_q) < ROWS_LIM) ? coord_t'(grid_rows_q) : ROWS_LIM;
	assign eff_cols = (coord_t'(grid_cols_q) < COLS_LIM) ? coord_t'(grid_cols_q) : COLS_LIM;
	assign org_r    = coord_t'(origin_row_q);
	assign org_c    = coord_t'(origin_col_q);
	assign org_ok   = (org_r < eff_rows) && (org_c < eff_cols);

	// skip checks
	assign invalid = (range_q == 16'd0) || (range_q == 16'hFFFF);
	assign diff    = (range_q > next_q) ? range_q - next_q : next_q - range_q;
	assign jump    = has_next_q && (diff > jump_limit_q);

	// sine lookup, folded to the first quadrant
	assign entry     = theta_q[23 -: LOG];
	assign lut_entry = cmd.sine ? entry : entry + LOG'(QTR);
	assign quad      = lut_entry[LOG-1 -: 2];
	assign lut_k     = quad[0] ? (LOG-1)'(QTR) - (LOG-1)'(lut_entry[LOG-3:0])
		: (LOG-1)'(lut_entry[LOG-3:0]);
	assign lut_val   = quad[1] ? -{1'b0, sine_rom[lut_k]} : {1'b0, sine_rom[lut_k]};

	// shared multiplier operand: sine for the column, cosine for the row
	always_comb begin
		if (cmd.cosine) begin
			mag = sin_q[15] ? 15'(-sin_q) : sin_q[14:0];
		end else begin
			mag = cos_q[15] ? 15'(-cos_q) : cos_q[14:0];
		end
	end

	// stamp cell under the walker
	assign nr       = row_q + coord_t'(sj_q) - coord_t'(STAMP_RADIUS);
	assign nc       = col_q + coord_t'(sk_q) - coord_t'(STAMP_RADIUS);
	assign stamp_in = (nr >= 0) && (nc >= 0) && (nr < eff_rows) && (nc < eff_cols);
	assign read_in  = (coord_t'(rrow_q) < eff_rows) && (coord_t'(rcol_q) < eff_cols);

	assign sts.op         = op_t'(op);
	assign sts.skip       = invalid || jump;
	assign sts.sweep_last = (sweep_q == AW'(DEPTH - 1));
	assign sts.stamp_last = (sj_q == span_cnt_t'(SPAN - 1)) && (sk_q == span_cnt_t'(SPAN - 1));

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = CELL_EMPTY;
		mem_addr  = cell_addr(coord_t'(rrow_q), coord_t'(rcol_q));
		if (cmd.sweep) begin
			mem_we   = 1'b1;
			mem_addr = sweep_q;
		end else if (cmd.origin_wr) begin
			mem_we    = clr_ok_q;
			mem_addr  = clr_addr_q;
			mem_wdata = CELL_ORIGIN;
		end else if (cmd.stamp) begin
			mem_we    = stamp_in;
			mem_addr  = cell_addr(nr, nc);
			mem_wdata = CELL_OBST;
		end
	end

	logm_ram #(
		.WIDTH(3),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_per_mm_q <= RST_CELLS_PER_MM;
			angle_step_q   <= RST_ANGLE_STEP;
			heading_q      <= RST_HEADING;
			origin_row_q   <= RST_ORIGIN_ROW;
			origin_col_q   <= RST_ORIGIN_COL;
			grid_rows_q    <= RST_GRID_ROWS;
			grid_cols_q    <= RST_GRID_COLS;
			jump_limit_q   <= RST_JUMP_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CELLS_PER_MM: cells_per_mm_q <= cfg_data;
				REG_ANGLE_STEP:   angle_step_q   <= cfg_data;
				REG_HEADING:      heading_q      <= cfg_data;
				REG_ORIGIN_ROW:   origin_row_q   <= cfg_data[6:0];
				REG_ORIGIN_COL:   origin_col_q   <= cfg_data[8:0];
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data[7:0];
				REG_GRID_COLS:    grid_cols_q    <= cfg_data[9:0];
				REG_JUMP_LIMIT:   jump_limit_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// clear control and stamp walker: sweep counter, latched origin write and stamp counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			clr_ok_q   <= RST_ORG_OK;
			clr_addr_q <= RST_ORG_ADDR;
			sj_q       <= '0;
			sk_q       <= '0;
		end else begin
			if (cmd.capture) begin
				sweep_q    <= '0;
				clr_ok_q   <= org_ok;
				clr_addr_q <= cell_addr(org_r, org_c);
			end else if (cmd.sweep) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.round_row) begin
				sj_q <= '0;
				sk_q <= '0;
			end else if (cmd.stamp) begin
				if (sk_q == span_cnt_t'(SPAN - 1)) begin
					sk_q <= '0;
					sj_q <= sj_q + 1'b1;
				end else begin
					sk_q <= sk_q + 1'b1;
				end
			end
		end
	end

	// payload and geometry registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op_t'(op);
			idx_q      <= beam_index;
			range_q    <= range_mm;
			next_q     <= next_range_mm;
			has_next_q <= has_next;
			rrow_q     <= read_row;
			rcol_q     <= read_col;
			status_w_q <= ST_DONE;
			cell_w_q   <= CELL_EMPTY;
		end
		if (cmd.check) begin
			status_w_q <= invalid ? ST_INVALID : (jump ? ST_JUMP : ST_DONE);
			theta_q    <= 24'(36'(idx_q) * 36'(angle_step_q)) - heading_q;
			dist_q     <= 40'(range_q) * 40'(cells_per_mm_q);
		end
		if (cmd.sine) begin
			sin_q <= lut_val;
		end
		if (cmd.cosine) begin
			cos_q <= lut_val;
		end
		if (cmd.cosine || cmd.mul_row) begin
			prod_q     <= 55'(dist_q) * 55'(mag);
			prod_neg_q <= cmd.cosine ? sin_q[15] : cos_q[15];
		end
		if (cmd.mul_row) begin
			col_q <= org_c + round_q39(prod_q, prod_neg_q);
		end
		if (cmd.round_row) begin
			row_q <= org_r + round_q39(prod_q, prod_neg_q);
		end
		if (cmd.read_cap) begin
			cell_w_q <= (read_in && op_q == OP_READ) ? mem_rdata : CELL_EMPTY;
		end
		if (cmd.out_load) begin
			status_q <= status_w_q;
			cell_q   <= cell_w_q;
		end
	end

endmodule

### rtl/lidar_occupancy_grid_marker.sv
// lidar_occupancy_grid_marker: obstacle grid built from lidar beams
// one item at a time; for a beam the stamp walks the single-port grid memory one cell per cycle;
// a result stalled at the output holds the next one in its last step
// at reset the registers take their reset values and a clearing pass empties the grid and marks
// the origin; no item is taken until it ends
module lidar_occupancy_grid_marker
	import logm_pkg::*;
#(
	parameter int ROWS_MAX     = 128,
	parameter int COLS_MAX     = 512,
	parameter int SINE_ENTRIES = 1024,
	parameter int STAMP_RADIUS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [11:0] beam_index,
	input  logic [15:0] range_mm,
	input  logic [15:0] next_range_mm,
	input  logic        has_next,
	input  logic [6:0]  read_row,
	input  logic [8:0]  read_col,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  cell_value,
	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logm_cmd_t cmd;
	logm_sts_t sts;

	// sequencer: one state per step of an item, result transfer from the finish state
	logm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: config, projection through the shared multiplier, grid memory
	logm_dp #(
		.ROWS_MAX    (ROWS_MAX),
		.COLS_MAX    (COLS_MAX),
		.SINE_ENTRIES(SINE_ENTRIES),
		.STAMP_RADIUS(STAMP_RADIUS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.beam_index   (beam_index),
		.range_mm     (range_mm),
		.next_range_mm(next_range_mm),
		.has_next     (has_next),
		.read_row     (read_row),
		.read_col     (read_col),
		.status       (status),
		.cell_value   (cell_value)
	);

endmodule
